// ===== rtl/core/msc_pkg.sv =====
// Package: shared types and constants for the motor stroke controller.
`timescale 1ns / 1ps
`default_nettype none
package msc_pkg;
  localparam int unsigned PwmMaxDefault = 49;
  localparam int unsigned PwmW = 10;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_UP   = 2'd1;
  localparam logic [1:0] CMD_DOWN = 2'd2;

  localparam logic [1:0] POS_UNKNOWN = 2'd0;
  localparam logic [1:0] POS_TOP     = 2'd1;
  localparam logic [1:0] POS_BOTTOM  = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_ALREADY = 3'd1;
  localparam logic [2:0] ST_NOREF  = 3'd2;
  localparam logic [2:0] ST_SENSOR = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_OBSTACLE = 3'd5;
  localparam logic [2:0] ST_STUCK  = 3'd6;

  localparam logic [2:0] REG_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_IGNORE  = 3'd1;
  localparam logic [2:0] REG_OVER    = 3'd2;
  localparam logic [2:0] REG_PAUSE   = 3'd3;
  localparam logic [2:0] REG_SAMPLE  = 3'd4;
  localparam logic [2:0] REG_FAILS   = 3'd5;
  localparam logic [2:0] REG_LIMIT   = 3'd6;
  localparam logic [2:0] REG_VTARGET = 3'd7;

  // command from controller to datapath
  typedef struct packed {
    logic start; // start a duty and threshold calculation
    logic [14:0] v;
    logic [12:0] i;
  } msc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic done;
    logic [9:0] duty;
    logic [11:0] thr;
  } msc_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/msc_reg_div.sv =====
// Datapath: duty and current threshold from a sample via a shared serial divider.
`timescale 1ns / 1ps
`default_nettype none
module msc_reg_div #(
  parameter int unsigned PwmMax = msc_pkg::PwmMaxDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [11:0] limit_i,
  input  wire logic [13:0] vtarget_i,
  input  wire msc_pkg::msc_cmd_t cmd_i,
  output msc_pkg::msc_sts_t sts_o
);
  import msc_pkg::*;
  localparam int unsigned QW = 14;
  localparam int unsigned NW = 28;
  localparam logic [PwmW-1:0] PmC = PwmW'(PwmMax);

  typedef enum logic [1:0] {S_IDLE, S_DUTY, S_THR} st_e;
  st_e st_q;
  logic [NW-1:0] rem_q, rem_d, num_q;
  logic [15:0] den_q;
  logic [QW-1:0] quo_q;
  logic [4:0] cnt_q;
  logic [PwmW-1:0] duty_q;
  logic [11:0] thr_q;
  logic done_q;
  logic [NW:0] trial;
  logic [14:0] nsum;
  logic [NW-1:0] prodd, prodt;

  assign nsum = {1'b0, vtarget_i} + {1'b0, cmd_i.i, 1'b0};
  assign prodd = NW'(nsum) * NW'(PmC);
  assign prodt = NW'(nsum) * NW'(limit_i);
  assign trial = {rem_q, num_q[NW-1]} - {{(NW-15){1'b0}}, den_q};
  assign rem_d = trial[NW] ? {rem_q[NW-2:0], num_q[NW-1]} : trial[NW-1:0];
  assign sts_o = '{done: done_q, duty: duty_q, thr: thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      done_q <= 1'b0;
      cnt_q <= '0;
      rem_q <= '0;
      num_q <= '0;
      den_q <= '0;
      quo_q <= '0;
      duty_q <= '0;
      thr_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (cmd_i.start) begin
            if (cmd_i.v < 15'd500) begin
              duty_q <= PmC >> 1;
              thr_q <= limit_i >> 1;
              done_q <= 1'b1;
            end else if (nsum >= cmd_i.v) begin
              duty_q <= PmC;
              thr_q <= limit_i;
              done_q <= 1'b1;
            end else begin
              // round(n*p / v): dividend 2*n*p + v, divisor 2v
              num_q <= (prodd << 1) + NW'(cmd_i.v);
              rem_q <= '0;
              den_q <= {cmd_i.v, 1'b0};
              cnt_q <= 5'(NW);
              quo_q <= '0;
              st_q <= S_DUTY;
            end
          end
        end
        S_DUTY, S_THR: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 5'd1;
            rem_q <= rem_d;
            quo_q <= {quo_q[QW-2:0], !trial[NW]};
            num_q <= num_q << 1;
          end else if (st_q == S_DUTY) begin
            duty_q <= PwmW'(quo_q);
            num_q <= (prodt << 1) + NW'(den_q >> 1);
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= 5'(NW);
            st_q <= S_THR;
          end else begin
            thr_q <= 12'(quo_q);
            done_q <= 1'b1;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/msc_ctrl.sv =====
// Controller: stroke state machine, timers and result register.
`timescale 1ns / 1ps
`default_nettype none
module msc_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] command_i,
  input  wire logic [1:0] endstop_pos_i,
  input  wire logic sensor_ok_i,
  input  wire logic [14:0] bus_voltage_mv_i,
  input  wire logic [11:0] current_ma_i,
  output logic out_valid,
  input  wire logic out_ready,
  output logic drive_on_o,
  output logic drive_up_o,
  output logic [5:0] duty_o,
  output logic done_res_o,
  output logic [2:0] status_o,
  output logic [1:0] expected_pos_o,
  output logic busy_res_o,
  input  wire logic [15:0] timeout_i,
  input  wire logic [15:0] ignore_i,
  input  wire logic [15:0] over_i,
  input  wire logic [15:0] pause_i,
  input  wire logic [9:0] sample_i,
  input  wire logic [2:0] fails_i,
  output msc_pkg::msc_cmd_t cmd_o,
  input  wire msc_pkg::msc_sts_t sts_i
);
  import msc_pkg::*;
  typedef enum logic [1:0] {P_IDLE, P_SETTLE, P_DRIVE, P_PAUSE} ph_e;
  typedef enum logic [1:0] {F_WAIT, F_CALC, F_OUT} fsm_e;

  fsm_e fsm_q;
  ph_e ph_q;
  logic rev_q, up_q, ovr_q, from_settle_q;
  logic [1:0] spos_q;
  logic [15:0] el_q, ot_q;
  logic [9:0] stm_q;
  logic [2:0] fc_q;
  logic [PwmW-1:0] duty_q;
  logic [11:0] thr_q;
  logic go_q;
  logic [14:0] v_q;
  logic [11:0] i_q;
  logic [15:0] el_n, ot_n;
  logic [9:0] stm_n;
  logic [2:0] fc_n;

  assign in_ready = (fsm_q == F_WAIT) && !out_valid;
  assign cmd_o.v = v_q;
  assign cmd_o.i = {1'b0, i_q};
  assign cmd_o.start = go_q;
  assign el_n = (el_q == 16'hFFFF) ? el_q : el_q + 16'd1;
  assign ot_n = (ot_q == 16'hFFFF) ? ot_q : ot_q + 16'd1;
  assign stm_n = (stm_q == 10'h3FF) ? stm_q : stm_q + 10'd1;
  assign fc_n = (fc_q == 3'd7) ? fc_q : fc_q + 3'd1;

  function automatic logic up_of(ph_e p, logic r, logic u);
    logic x;
    x = 1'b0;
    unique case (p)
      P_SETTLE: x = r & u;
      P_DRIVE: x = u ^ r;
      P_PAUSE: x = u;
      default: x = 1'b0;
    endcase
    return x;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= F_WAIT;
      ph_q <= P_IDLE;
      rev_q <= 1'b0; up_q <= 1'b0; ovr_q <= 1'b0; from_settle_q <= 1'b0;
      spos_q <= '0; el_q <= '0; ot_q <= '0; stm_q <= '0; fc_q <= '0;
      duty_q <= '0; thr_q <= '0; go_q <= 1'b0; v_q <= '0; i_q <= '0;
      out_valid <= 1'b0;
      drive_on_o <= 1'b0; drive_up_o <= 1'b0; duty_o <= '0; done_res_o <= 1'b0;
      status_o <= '0; expected_pos_o <= '0; busy_res_o <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (fsm_q)
        F_WAIT: begin
          if (in_valid && in_ready) begin
            v_q <= bus_voltage_mv_i; i_q <= current_ma_i;
            fsm_q <= F_OUT;
            if (command_i == CMD_UP || command_i == CMD_DOWN) begin
              if (ph_q != P_IDLE) begin
                done_res_o <= 1'b0; status_o <= ST_OK; expected_pos_o <= '0;
              end else if (endstop_pos_i == (command_i == CMD_UP ? POS_TOP : POS_BOTTOM)) begin
                done_res_o <= 1'b1; status_o <= ST_ALREADY; expected_pos_o <= '0;
              end else if (endstop_pos_i != POS_TOP && endstop_pos_i != POS_BOTTOM) begin
                done_res_o <= 1'b1; status_o <= ST_NOREF; expected_pos_o <= '0;
              end else begin
                up_q <= (command_i == CMD_UP);
                spos_q <= endstop_pos_i;
                rev_q <= 1'b0; stm_q <= '0; el_q <= '0; fc_q <= '0;
                ovr_q <= 1'b0; ot_q <= '0; duty_q <= '0; thr_q <= '0;
                if (!sensor_ok_i) begin
                  ph_q <= P_IDLE;
                  done_res_o <= 1'b1; status_o <= ST_SENSOR;
                  expected_pos_o <= endstop_pos_i;
                end else begin
                  ph_q <= P_SETTLE;
                  done_res_o <= 1'b0; status_o <= ST_OK; expected_pos_o <= '0;
                end
              end
            end else if (command_i == CMD_TICK) begin
              done_res_o <= 1'b0; status_o <= ST_OK; expected_pos_o <= '0;
              if (ph_q == P_SETTLE) begin
                stm_q <= stm_n;
                if (stm_n >= sample_i) begin
                  if (!sensor_ok_i) begin
                    ph_q <= P_IDLE;
                    done_res_o <= 1'b1; status_o <= ST_SENSOR;
                  end else begin
                    fsm_q <= F_CALC; from_settle_q <= 1'b1; go_q <= 1'b1;
                  end
                end
              end else if (ph_q == P_DRIVE) begin
                el_q <= el_n;
                if (ovr_q) ot_q <= ot_n;
                if (endstop_pos_i == ((up_q ^ rev_q) ? POS_TOP : POS_BOTTOM)) begin
                  ph_q <= P_IDLE; done_res_o <= 1'b1;
                  status_o <= rev_q ? ST_OBSTACLE : ST_OK;
                  expected_pos_o <= rev_q ? spos_q : endstop_pos_i;
                end else if (el_n >= timeout_i) begin
                  ph_q <= P_IDLE; done_res_o <= 1'b1;
                  status_o <= rev_q ? ST_STUCK : ST_TIMEOUT;
                end else begin
                  stm_q <= stm_n;
                  if (stm_n >= sample_i) begin
                    stm_q <= '0;
                    if (!sensor_ok_i) begin
                      fc_q <= fc_n;
                      if (fc_n >= fails_i) begin
                        ph_q <= P_IDLE; done_res_o <= 1'b1; status_o <= ST_SENSOR;
                      end
                    end else begin
                      fc_q <= '0;
                      fsm_q <= F_CALC; from_settle_q <= 1'b0; go_q <= 1'b1;
                    end
                  end
                end
              end else if (ph_q == P_PAUSE) begin
                ot_q <= ot_n;
                if (ot_n >= pause_i) begin
                  ph_q <= P_SETTLE; rev_q <= 1'b1; stm_q <= '0; ot_q <= '0;
                end
              end
            end else begin
              done_res_o <= 1'b0; status_o <= ST_OK; expected_pos_o <= '0;
            end
          end
        end
        F_CALC: begin
          go_q <= 1'b0;
          if (sts_i.done) begin
            fsm_q <= F_OUT;
            duty_q <= sts_i.duty; thr_q <= sts_i.thr;
            if (from_settle_q) begin
              ph_q <= P_DRIVE; el_q <= '0; stm_q <= '0; fc_q <= '0;
              ovr_q <= 1'b0; ot_q <= '0;
            end else if (el_q < ignore_i || i_q <= sts_i.thr) begin
              ovr_q <= 1'b0;
            end else if (!ovr_q) begin
              ovr_q <= 1'b1; ot_q <= '0;
            end else if (ot_q >= over_i) begin
              if (rev_q) begin
                ph_q <= P_IDLE; done_res_o <= 1'b1; status_o <= ST_STUCK;
              end else begin
                duty_q <= '0; ph_q <= P_PAUSE; ovr_q <= 1'b0; ot_q <= '0;
              end
            end
          end
        end
        F_OUT: begin
          fsm_q <= F_WAIT;
          out_valid <= 1'b1;
          if (done_res_o) begin
            ph_q <= P_IDLE; rev_q <= 1'b0; duty_q <= '0; thr_q <= '0;
            ovr_q <= 1'b0; ot_q <= '0; fc_q <= '0; stm_q <= '0; el_q <= '0;
            drive_on_o <= 1'b0; busy_res_o <= 1'b0; drive_up_o <= 1'b0; duty_o <= '0;
          end else begin
            drive_on_o <= (ph_q != P_IDLE); busy_res_o <= (ph_q != P_IDLE);
            drive_up_o <= up_of(ph_q, rev_q, up_q);
            duty_o <= duty_q[5:0];
          end
        end
        default: fsm_q <= F_WAIT;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/motor_stroke_controller.sv =====
// Top level: motor stroke controller with configuration registers.
// One result per transaction. A tick that takes a good sensor sample runs two
// 28-step serial divisions (duty, then current threshold), unless the bus voltage
// is below 500 mV or the demand sum reaches it; no new input is taken until the
// result of the last one has been accepted.
`timescale 1ns / 1ps
`default_nettype none
module motor_stroke_controller #(
  parameter int unsigned PwmMax = msc_pkg::PwmMaxDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] command_i,
  input  wire logic [1:0] endstop_pos_i,
  input  wire logic sensor_ok_i,
  input  wire logic [14:0] bus_voltage_mv_i,
  input  wire logic [11:0] current_ma_i,
  output logic out_valid,
  input  wire logic out_ready,
  output logic drive_on_o,
  output logic drive_up_o,
  output logic [5:0] duty_o,
  output logic done_res_o,
  output logic [2:0] status_o,
  output logic [1:0] expected_pos_o,
  output logic busy_res_o,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import msc_pkg::*;
  logic [15:0] tmo_q, ign_q, ovr_q, pse_q;
  logic [9:0] smp_q;
  logic [2:0] fl_q;
  logic [11:0] lim_q;
  logic [13:0] vt_q;
  msc_cmd_t cmd;
  msc_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= 16'd25000; ign_q <= 16'd250; ovr_q <= 16'd250; pse_q <= 16'd250;
      smp_q <= 10'd40; fl_q <= 3'd3; lim_q <= 12'd450; vt_q <= 14'd6400;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        REG_TIMEOUT: tmo_q <= cfg_data_i;
        REG_IGNORE: ign_q <= cfg_data_i;
        REG_OVER: ovr_q <= cfg_data_i;
        REG_PAUSE: pse_q <= cfg_data_i;
        REG_SAMPLE: smp_q <= cfg_data_i[9:0];
        REG_FAILS: fl_q <= cfg_data_i[2:0];
        REG_LIMIT: lim_q <= cfg_data_i[11:0];
        REG_VTARGET: vt_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  msc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .command_i, .endstop_pos_i,
    .sensor_ok_i, .bus_voltage_mv_i, .current_ma_i, .out_valid, .out_ready,
    .drive_on_o, .drive_up_o, .duty_o, .done_res_o, .status_o,
    .expected_pos_o, .busy_res_o,
    .timeout_i(tmo_q), .ignore_i(ign_q), .over_i(ovr_q), .pause_i(pse_q),
    .sample_i(smp_q), .fails_i(fl_q), .cmd_o(cmd), .sts_i(sts)
  );

  msc_reg_div #(.PwmMax(PwmMax)) u_div (
    .clk_i, .rst_ni, .limit_i(lim_q), .vtarget_i(vt_q), .cmd_i(cmd), .sts_o(sts)
  );
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the motor stroke controller: directed and random strokes checked per transaction.
`timescale 1ns / 1ps
module tb;
  import msc_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic [1:0] POS_BAD = 2'd3;
  localparam int unsigned PWM_FULL = PwmMaxDefault;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef enum logic [1:0] {PH_IDLE, PH_SETTLE, PH_DRIVE, PH_PAUSE} stroke_phase_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] pos;
    logic ok;
    logic [14:0] mv;
    logic [11:0] ma;
  } door_item_t;

  typedef struct packed {
    logic drive_on;
    logic drive_up;
    logic [5:0] duty;
    logic done;
    logic [2:0] status;
    logic [1:0] exp_pos;
    logic busy;
  } door_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command_i = CMD_TICK;
  logic [1:0] endstop_pos_i = POS_UNKNOWN;
  logic sensor_ok_i = 1'b0;
  logic [14:0] bus_voltage_mv_i = '0;
  logic [11:0] current_ma_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic drive_on_o, drive_up_o, done_res_o, busy_res_o;
  logic [5:0] duty_o;
  logic [2:0] status_o;
  logic [1:0] expected_pos_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index_i = REG_TIMEOUT;
  logic [15:0] cfg_data_i = '0;

  motor_stroke_controller dut (.*);

  always #10 clk_i = ~clk_i;

  door_item_t pending_items[$];
  door_result_t expected_results[$];
  logic in_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned strokes_done = 0;
  int unsigned idle_cycles = 0;

  // configuration and state mirror
  logic [15:0] timeout_ms, ignore_ms, over_ms, pause_ms;
  logic [9:0] sample_ms;
  logic [2:0] fails_max;
  logic [11:0] limit_ma;
  logic [13:0] vtarget_mv;
  stroke_phase_e phase;
  logic reversing, move_up;
  logic [1:0] start_pos;
  logic [15:0] elapsed, over_timer;
  logic [9:0] sample_timer;
  logic [2:0] fail_count;
  logic over_active;
  logic [5:0] duty_now;
  logic [11:0] threshold;

  function automatic void clear_stroke();
    reversing = 1'b0; elapsed = '0; sample_timer = '0; fail_count = '0;
    over_active = 1'b0; over_timer = '0; duty_now = '0; threshold = '0;
  endfunction

  function automatic void mirror_reset();
    timeout_ms = 16'd25000; ignore_ms = 16'd250; over_ms = 16'd250; pause_ms = 16'd250;
    sample_ms = 10'd40; fails_max = 3'd3; limit_ma = 12'd450; vtarget_mv = 14'd6400;
    phase = PH_IDLE; move_up = 1'b0; start_pos = POS_UNKNOWN;
    clear_stroke();
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_TIMEOUT: timeout_ms = val;
      REG_IGNORE: ignore_ms = val;
      REG_OVER: over_ms = val;
      REG_PAUSE: pause_ms = val;
      REG_SAMPLE: sample_ms = val[9:0];
      REG_FAILS: fails_max = val[2:0];
      REG_LIMIT: limit_ma = val[11:0];
      REG_VTARGET: vtarget_mv = val[13:0];
      default: ;
    endcase
  endfunction

  function automatic void update_duty(longint unsigned mv, longint unsigned ma);
    longint unsigned num;
    if (mv < 500) begin
      duty_now = 6'(PWM_FULL / 2);
      threshold = limit_ma >> 1;
      return;
    end
    num = longint'(vtarget_mv) + 2 * ma;
    if (num >= mv) begin
      duty_now = 6'(PWM_FULL);
      threshold = limit_ma;
      return;
    end
    duty_now = 6'((2 * num * PWM_FULL + mv) / (2 * mv));
    threshold = 12'((2 * longint'(limit_ma) * num + mv) / (2 * mv));
  endfunction

  function automatic door_result_t pack_result(logic done, logic [2:0] st, logic [1:0] ep);
    door_result_t r;
    r.busy = (phase != PH_IDLE);
    r.drive_on = r.busy;
    case (phase)
      PH_SETTLE: r.drive_up = reversing ? move_up : 1'b0;
      PH_DRIVE: r.drive_up = move_up ^ reversing;
      PH_PAUSE: r.drive_up = move_up;
      default: r.drive_up = 1'b0;
    endcase
    r.duty = duty_now;
    r.done = done;
    r.status = st;
    r.exp_pos = ep;
    return r;
  endfunction

  function automatic door_result_t end_stroke(logic [2:0] st, logic [1:0] ep);
    phase = PH_IDLE;
    clear_stroke();
    return pack_result(1'b1, st, ep);
  endfunction

  function automatic logic [15:0] inc16(logic [15:0] x);
    return (x != 16'hFFFF) ? x + 16'd1 : x;
  endfunction

  function automatic door_result_t stroke_step(door_item_t it);
    logic [1:0] pos, tgt;
    pos = it.pos;
    if (it.cmd == CMD_UP || it.cmd == CMD_DOWN) begin
      tgt = (it.cmd == CMD_UP) ? POS_TOP : POS_BOTTOM;
      if (phase != PH_IDLE) return pack_result(1'b0, ST_OK, POS_UNKNOWN);
      if (pos == tgt) return pack_result(1'b1, ST_ALREADY, POS_UNKNOWN);
      if (pos != POS_TOP && pos != POS_BOTTOM) return pack_result(1'b1, ST_NOREF, POS_UNKNOWN);
      move_up = (it.cmd == CMD_UP);
      start_pos = pos;
      if (!it.ok) return end_stroke(ST_SENSOR, pos);
      phase = PH_SETTLE;
      clear_stroke();
      return pack_result(1'b0, ST_OK, POS_UNKNOWN);
    end
    if (it.cmd == CMD_NOP) return pack_result(1'b0, ST_OK, POS_UNKNOWN);
    case (phase)
      PH_SETTLE: begin
        if (sample_timer != 10'd1023) sample_timer++;
        if (sample_timer >= sample_ms) begin
          if (!it.ok) return end_stroke(ST_SENSOR, POS_UNKNOWN);
          update_duty(it.mv, it.ma);
          phase = PH_DRIVE;
          elapsed = '0; sample_timer = '0; fail_count = '0;
          over_active = 1'b0; over_timer = '0;
        end
      end
      PH_DRIVE: begin
        tgt = (move_up ^ reversing) ? POS_TOP : POS_BOTTOM;
        elapsed = inc16(elapsed);
        if (over_active) over_timer = inc16(over_timer);
        if (pos == tgt) return reversing ? end_stroke(ST_OBSTACLE, start_pos)
                                         : end_stroke(ST_OK, tgt);
        if (elapsed >= timeout_ms)
          return end_stroke(reversing ? ST_STUCK : ST_TIMEOUT, POS_UNKNOWN);
        if (sample_timer != 10'd1023) sample_timer++;
        if (sample_timer >= sample_ms) begin
          sample_timer = '0;
          if (!it.ok) begin
            if (fail_count != 3'd7) fail_count++;
            if (fail_count >= fails_max) return end_stroke(ST_SENSOR, POS_UNKNOWN);
          end else begin
            fail_count = '0;
            update_duty(it.mv, it.ma);
            if (elapsed < ignore_ms || it.ma <= threshold) begin
              over_active = 1'b0;
            end else if (!over_active) begin
              over_active = 1'b1;
              over_timer = '0;
            end else if (over_timer >= over_ms) begin
              if (reversing) return end_stroke(ST_STUCK, POS_UNKNOWN);
              duty_now = '0;
              phase = PH_PAUSE;
              over_active = 1'b0;
              over_timer = '0;
            end
          end
        end
      end
      PH_PAUSE: begin
        over_timer = inc16(over_timer);
        if (over_timer >= pause_ms) begin
          phase = PH_SETTLE;
          reversing = 1'b1;
          sample_timer = '0;
          over_timer = '0;
        end
      end
      default: ;
    endcase
    return pack_result(1'b0, ST_OK, POS_UNKNOWN);
  endfunction

  // driver
  always @(negedge clk_i) begin
    door_item_t it;
    if (rst_ni && (!in_valid || in_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        command_i <= it.cmd;
        endstop_pos_i <= it.pos;
        sensor_ok_i <= it.ok;
        bus_voltage_mv_i <= it.mv;
        current_ma_i <= it.ma;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    door_item_t it;
    door_result_t got, want;
    in_taken <= in_valid && in_ready;
    if (out_valid && out_ready) begin
      got = '{drive_on_o, drive_up_o, duty_o, done_res_o, status_o, expected_pos_o, busy_res_o};
      results_seen++;
      if (got.done) strokes_done++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: expected %p, actual %p", $realtime, want, got);
        end
      end
    end
    if (in_valid && in_ready) begin
      it = '{command_i, endstop_pos_i, sensor_ok_i, bus_voltage_mv_i, current_ma_i};
      expected_results.push_back(stroke_step(it));
    end
    if (cfg_valid && cfg_ready) apply_register(cfg_index_i, cfg_data_i);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d transactions outstanding", expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void push_item(logic [1:0] cmd, logic [1:0] pos, logic ok,
                                    logic [14:0] mv, logic [11:0] ma);
    door_item_t it;
    it = '{cmd, pos, ok, mv, ma};
    pending_items.push_back(it);
  endfunction

  function automatic logic [14:0] rand_mv();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 15'($urandom_range(16000, 4000));
    if (r < 80) return 15'($urandom_range(499));
    return 15'($urandom_range(32767));
  endfunction

  function automatic logic [11:0] rand_ma();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 12'($urandom_range(400));
    if (r < 90) return 12'($urandom_range(4095, 400));
    return 12'hFFF;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(int unsigned s[8]);
    wait_drained();
    for (int k = 0; k < 8; k++) write_register(k[2:0], s[k][15:0]);
  endtask

  function automatic int unsigned push_stroke();
    logic up;
    logic [1:0] tgt, from;
    int unsigned len, r, n;
    up = 1'($urandom_range(1));
    tgt = up ? POS_TOP : POS_BOTTOM;
    from = ($urandom_range(99) < 85) ? (up ? POS_BOTTOM : POS_TOP) : 2'($urandom_range(3));
    push_item(up ? CMD_UP : CMD_DOWN, from, $urandom_range(99) < 95, rand_mv(), rand_ma());
    n = 1;
    len = $urandom_range(60, 3);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 3) push_item(2'($urandom_range(3)), 2'($urandom_range(3)),
                           1'($urandom_range(1)), 15'($urandom_range(32767)),
                           12'($urandom_range(4095)));
      else if (r < 8) push_item(CMD_TICK, from, $urandom_range(99) < 90, rand_mv(), rand_ma());
      else if (r < 12) push_item(CMD_TICK, POS_BAD, $urandom_range(99) < 90, rand_mv(),
                                 rand_ma());
      else push_item(CMD_TICK, POS_UNKNOWN, $urandom_range(99) < 90, rand_mv(), rand_ma());
      n++;
    end
    push_item(CMD_TICK, ($urandom_range(99) < 70) ? tgt : 2'($urandom_range(3)),
              1'($urandom_range(1)), rand_mv(), rand_ma());
    return n + 1;
  endfunction

  task automatic run_random(int unsigned count, int unsigned idle_pct, int unsigned stall_pct);
    int unsigned pushed;
    bit paused;
    pushed = 0;
    paused = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (pushed < count) begin
      pushed += push_stroke();
      if (!paused && pushed > count / 2) begin
        // hold off until every pending result is back
        paused = 1;
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
          @(posedge clk_i);
      end
    end
  endtask

  int unsigned settings[6][8] = '{
    '{40, 2, 2, 3, 1, 2, 300, 6400},
    '{0, 0, 0, 0, 1, 1, 0, 0},
    '{65535, 65535, 65535, 65535, 1023, 7, 4095, 16383},
    '{120, 5, 3, 4, 3, 3, 200, 9000},
    '{60, 1, 1, 1, 2, 4, 100, 12000},
    '{25000, 250, 250, 250, 2, 3, 450, 6400}
  };
  int unsigned idle_modes[6][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{13, 13}, '{0, 0}, '{78, 0}};

  initial begin
    mirror_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    load_settings(settings[0]);
    push_item(CMD_TICK, POS_BAD, 1'b0, 15'h7FFF, 12'hFFF);
    push_item(CMD_NOP, POS_TOP, 1'b1, 15'd0, 12'd0);
    push_item(CMD_UP, POS_TOP, 1'b1, 15'd7000, 12'd100);
    push_item(CMD_DOWN, POS_BOTTOM, 1'b1, 15'd7000, 12'd100);
    push_item(CMD_UP, POS_UNKNOWN, 1'b1, 15'd7000, 12'd100);
    push_item(CMD_UP, POS_BAD, 1'b1, 15'd7000, 12'd100);
    push_item(CMD_DOWN, POS_TOP, 1'b0, 15'd7000, 12'd100);
    push_item(CMD_DOWN, POS_TOP, 1'b1, 15'd7000, 12'd100);
    push_item(CMD_UP, POS_BOTTOM, 1'b1, 15'd7000, 12'd100);
    push_item(CMD_TICK, POS_UNKNOWN, 1'b0, 15'd7000, 12'd100);
    push_item(CMD_DOWN, POS_TOP, 1'b1, 15'd7000, 12'd100);
    push_item(CMD_TICK, POS_UNKNOWN, 1'b1, 15'd100, 12'd50);
    push_item(CMD_TICK, POS_UNKNOWN, 1'b1, 15'd0, 12'd0);
    push_item(CMD_NOP, POS_UNKNOWN, 1'b1, 15'd9000, 12'd200);
    push_item(CMD_TICK, POS_BOTTOM, 1'b1, 15'd9000, 12'd200);
    push_item(CMD_UP, POS_BOTTOM, 1'b1, 15'd12000, 12'd10);
    push_item(CMD_TICK, POS_UNKNOWN, 1'b1, 15'h7FFF, 12'hFFF);
    push_item(CMD_TICK, POS_UNKNOWN, 1'b1, 15'd20000, 12'hFFF);
    push_item(CMD_TICK, POS_UNKNOWN, 1'b1, 15'd20000, 12'hFFF);
    push_item(CMD_TICK, POS_TOP, 1'b1, 15'd20000, 12'd0);
    for (int p = 0; p < 6; p++) begin
      if (p > 0) load_settings(settings[p]);
      run_random(200, idle_modes[p][0], idle_modes[p][1]);
    end
    wait_drained();
    $display("covered %0d results over 6 register settings, %0d strokes ended or refused",
             results_seen, strokes_done);
    $display("idle modes: none, sender gaps, receiver stalls, both; mismatches: %0d",
             mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
